// ===== rtl/imuf_pkg.sv =====
// ----------------------------------------------------------------------------
// imuf_pkg
// Shared constants and types for the IMU serial frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imuf_pkg;

  // Header bytes and payload length
  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'h00;
  localparam int         PAYLOAD_LEN = 13;
  localparam int         DATA_LEN    = PAYLOAD_LEN - 1;
  localparam int         CNT_W       = $clog2(PAYLOAD_LEN);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DATA_LEN);

  // Yaw wrap detection and turn tracking
  localparam logic signed [15:0] YAW_LIMIT_CD = 16'sd15000;
  localparam int                 TURN_W       = 11;
  localparam logic signed [TURN_W-1:0] TURN_MAX = 11'sd1023;
  localparam int                 ANGLE_W      = 28;
  localparam logic signed [ANGLE_W-1:0] TURN_CD = 28'sd36000;
  localparam int                 OFFSET_W     = 24;

  // One decoded frame, presented on the cycle of its checksum byte
  typedef struct packed {
    logic               last;
    logic               ok;
    logic [7:0]         index;
    logic signed [15:0] yaw;
    logic signed [15:0] heading_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [7:0]  turn_number;
  } frm_t;

endpackage

`default_nettype wire

// ===== rtl/imuf_framer.sv =====
// ----------------------------------------------------------------------------
// imuf_framer
// Header hunt, payload collection and checksum check, one byte per fired cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imuf_framer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic [7:0]     rx_byte,
  output imuf_pkg::frm_t      frame
);

  typedef enum logic [1:0] {
    PH_PENDING = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_SYNC    = 2'd2
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [imuf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  logic [7:0]                    payload_r [imuf_pkg::DATA_LEN];
  logic                          last;

  assign last = (phase_r == PH_SYNC) && (cnt_r == imuf_pkg::LAST_CNT);

  // Unpack little-endian fields from the stored payload
  always_comb begin
    frame.last         = last;
    frame.ok           = (sum_r == rx_byte);
    frame.index        = payload_r[0];
    frame.yaw          = {payload_r[2], payload_r[1]};
    frame.heading_rate = {payload_r[4], payload_r[3]};
    frame.accel_x      = {payload_r[6], payload_r[5]};
    frame.accel_y      = {payload_r[8], payload_r[7]};
    frame.accel_z      = {payload_r[10], payload_r[9]};
    frame.turn_number  = payload_r[11];
  end

  // Advance the sync phase and payload counters
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    case (phase_r)
      PH_CONFIRM: begin
        if (rx_byte == imuf_pkg::HDR_SECOND) begin
          phase_nxt = PH_SYNC;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end else begin
          phase_nxt = PH_PENDING;
        end
      end
      PH_SYNC: begin
        if (last) begin
          phase_nxt = PH_PENDING;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          sum_nxt = sum_r + rx_byte;
        end
      end
      default: begin
        phase_nxt = (rx_byte == imuf_pkg::HDR_FIRST) ? PH_CONFIRM : PH_PENDING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PENDING;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Store payload data bytes, no reset needed
  always_ff @(posedge clk) begin
    if (fire && (phase_r == PH_SYNC) && !last) begin
      payload_r[cnt_r] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imuf_unwrap.sv =====
// ----------------------------------------------------------------------------
// imuf_unwrap
// Held fields, yaw turn tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module imuf_unwrap (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                take,
  input  wire imuf_pkg::frm_t                      frame,
  input  wire logic signed [imuf_pkg::OFFSET_W-1:0] offset,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic                                     out_checksum_ok,
  output logic [7:0]                               out_frame_index,
  output logic signed [15:0]                       out_yaw_cd,
  output logic signed [15:0]                       out_heading_rate,
  output logic signed [15:0]                       out_accel_x,
  output logic signed [15:0]                       out_accel_y,
  output logic signed [15:0]                       out_accel_z,
  output logic signed [7:0]                        out_turn_number,
  output logic signed [imuf_pkg::ANGLE_W-1:0]       out_unwrapped_angle
);

  localparam int AW = imuf_pkg::ANGLE_W;

  logic [7:0]                          idx_r, idx_nxt;
  logic signed [15:0]                  yaw_r, yaw_nxt;
  logic signed [15:0]                  rate_r, rate_nxt;
  logic signed [15:0]                  ax_r, ax_nxt;
  logic signed [15:0]                  ay_r, ay_nxt;
  logic signed [15:0]                  az_r, az_nxt;
  logic signed [7:0]                   tn_r, tn_nxt;
  logic signed [imuf_pkg::TURN_W-1:0]  turn_r, turn_nxt;
  logic signed [AW-1:0]                turn_cd_r, turn_cd_nxt;
  logic signed [AW-1:0]                angle_nxt;
  logic                                out_valid_r;

  // Select new or held fields
  always_comb begin
    idx_nxt  = frame.ok ? frame.index        : idx_r;
    yaw_nxt  = frame.ok ? frame.yaw          : yaw_r;
    rate_nxt = frame.ok ? frame.heading_rate : rate_r;
    ax_nxt   = frame.ok ? frame.accel_x      : ax_r;
    ay_nxt   = frame.ok ? frame.accel_y      : ay_r;
    az_nxt   = frame.ok ? frame.accel_z      : az_r;
    tn_nxt   = frame.ok ? frame.turn_number  : tn_r;
  end

  // Count wraps across +/-150 degrees, keep 36000*turns alongside the count
  always_comb begin
    turn_nxt    = turn_r;
    turn_cd_nxt = turn_cd_r;
    if (yaw_nxt < -imuf_pkg::YAW_LIMIT_CD) begin
      if (yaw_r > imuf_pkg::YAW_LIMIT_CD && turn_r < imuf_pkg::TURN_MAX) begin
        turn_nxt    = turn_r + 11'sd1;
        turn_cd_nxt = turn_cd_r + imuf_pkg::TURN_CD;
      end
    end else if (yaw_nxt > imuf_pkg::YAW_LIMIT_CD) begin
      if (yaw_r < -imuf_pkg::YAW_LIMIT_CD && turn_r > -imuf_pkg::TURN_MAX) begin
        turn_nxt    = turn_r - 11'sd1;
        turn_cd_nxt = turn_cd_r - imuf_pkg::TURN_CD;
      end
    end
    angle_nxt = AW'(yaw_nxt) + turn_cd_nxt + AW'(offset);
  end

  // Hold tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      yaw_r     <= '0;
      rate_r    <= '0;
      ax_r      <= '0;
      ay_r      <= '0;
      az_r      <= '0;
      tn_r      <= '0;
      turn_r    <= '0;
      turn_cd_r <= '0;
    end else if (take) begin
      idx_r     <= idx_nxt;
      yaw_r     <= yaw_nxt;
      rate_r    <= rate_nxt;
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
      az_r      <= az_nxt;
      tn_r      <= tn_nxt;
      turn_r    <= turn_nxt;
      turn_cd_r <= turn_cd_nxt;
    end
  end

  // Result valid: set on a new frame, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_checksum_ok     <= frame.ok;
      out_frame_index     <= idx_nxt;
      out_yaw_cd          <= yaw_nxt;
      out_heading_rate    <= rate_nxt;
      out_accel_x         <= ax_nxt;
      out_accel_y         <= ay_nxt;
      out_accel_z         <= az_nxt;
      out_turn_number     <= tn_nxt;
      out_unwrapped_angle <= angle_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/imu_uart_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// imu_uart_frame_parser_core
// Timing: an accepted byte is held in the input register; the result of a
// frame's checksum byte is registered into the result register when it fires.
// Throughput: one byte per cycle; only a stalled pending result holds input.
// Reset (rst_n low, synchronous): sync hunt restarts, held fields, turn count
// and angle offset clear to zero, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_uart_frame_parser_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic signed [imuf_pkg::OFFSET_W-1:0] cfg_wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [7:0]                           in_rx_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_checksum_ok,
  output logic [7:0]                                out_frame_index,
  output logic signed [15:0]                        out_yaw_cd,
  output logic signed [15:0]                        out_heading_rate,
  output logic signed [15:0]                        out_accel_x,
  output logic signed [15:0]                        out_accel_y,
  output logic signed [15:0]                        out_accel_z,
  output logic signed [7:0]                         out_turn_number,
  output logic signed [imuf_pkg::ANGLE_W-1:0]        out_unwrapped_angle
);

  logic                                 in_vld_r;
  logic [7:0]                           in_byte_r;
  logic signed [imuf_pkg::OFFSET_W-1:0] offset_r;
  imuf_pkg::frm_t                       frame;
  logic                                 out_free;
  logic                                 fire;
  logic                                 take;

  // Process the registered byte unless its result cannot be placed
  assign out_free = !out_valid || !out_stall;
  assign fire     = in_vld_r && (!frame.last || out_free);
  assign take     = fire && frame.last;
  assign in_stall = in_vld_r && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Angle offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  imuf_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .frame   (frame)
  );

  imuf_unwrap u_unwrap (
    .clk                 (clk),
    .rst_n               (rst_n),
    .take                (take),
    .frame               (frame),
    .offset              (offset_r),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_checksum_ok     (out_checksum_ok),
    .out_frame_index     (out_frame_index),
    .out_yaw_cd          (out_yaw_cd),
    .out_heading_rate    (out_heading_rate),
    .out_accel_x         (out_accel_x),
    .out_accel_y         (out_accel_y),
    .out_accel_z         (out_accel_z),
    .out_turn_number     (out_turn_number),
    .out_unwrapped_angle (out_unwrapped_angle)
  );

endmodule

`default_nettype wire
